// ===== rtl/shortest_job_first_queue_macros.svh =====
// assertion macros for the shortest job first run queue
// used by the checker only; needs nothing else
`ifndef SHORTEST_JOB_FIRST_QUEUE_MACROS_SVH
`define SHORTEST_JOB_FIRST_QUEUE_MACROS_SVH

// same-cycle implication, off during reset
`define SJFQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sjfq check failed");

// next-cycle implication, off during reset
`define SJFQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sjfq check failed");

// next-cycle implication that also holds across reset
`define SJFQ_ASSERT_NXT_ALL(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sjfq check failed");

`endif

// ===== rtl/sjfq_pkg.sv =====
// shared types and constants of the shortest job first run queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sjfq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int ID_BITS     = 12;
   localparam int EST_BITS    = 16;
   localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int QCNT_BITS   = 6;
   localparam int REQ_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int ENTRY_BITS  = ID_BITS + EST_BITS;

   localparam logic [EST_BITS-1:0] DEFAULT_EST_RESET = EST_BITS'(100);

   // request kinds; the unused code behaves as a peek
   typedef enum logic [REQ_BITS-1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_PEEK   = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch;   // capture request, clear scan
      logic step;    // read next slot
      logic commit;  // apply update, load response
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/sjfq_req_if.sv =====
// request channel of the run queue: valid, ready and request payload
// depends on sjfq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sjfq_req_if import sjfq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [REQ_BITS-1:0] req_type;
   logic [ID_BITS-1:0]  proc_id;
   logic [EST_BITS-1:0] est_time;

   modport source (output valid, output req_type, output proc_id, output est_time,
                   input ready);
   modport sink   (input valid, input req_type, input proc_id, input est_time,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/sjfq_rsp_if.sv =====
// response channel of the run queue: valid, ready and response payload
// depends on sjfq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sjfq_rsp_if import sjfq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   pick_valid;
   logic [ID_BITS-1:0]     pick_id;
   logic [EST_BITS-1:0]    pick_estimate;
   logic [QCNT_BITS-1:0]   queue_count;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output pick_valid, output pick_id, output pick_estimate,
                   output queue_count, output status, input ready);
   modport sink   (input valid, input pick_valid, input pick_id, input pick_estimate,
                   input queue_count, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/sjfq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sjfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sjfq_ctrl.sv =====
// sequencing state machine of the run queue
// depends on sjfq_pkg
`timescale 1ns / 1ps
`default_nettype none

module sjfq_ctrl import sjfq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire dp_status_type sts,
   output      ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         // last slot read still in flight
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/sjfq_dp.sv =====
// datapath of the run queue: slot store, scan accumulators, count and response register
// depends on sjfq_pkg and sjfq_ram
`timescale 1ns / 1ps
`default_nettype none

module sjfq_dp import sjfq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_cmd_type           cmd,
   output      dp_status_type          sts,
   input  wire logic [REQ_BITS-1:0]    req_type,
   input  wire logic [ID_BITS-1:0]     proc_id,
   input  wire logic [EST_BITS-1:0]    est_time,
   input  wire logic                   csr_we,
   input  wire logic [EST_BITS-1:0]    csr_wdata,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic                   pick_valid,
   output      logic [ID_BITS-1:0]     pick_id,
   output      logic [EST_BITS-1:0]    pick_estimate,
   output      logic [QCNT_BITS-1:0]   queue_count,
   output      logic [STATUS_BITS-1:0] status
);

   logic [EST_BITS-1:0]    default_est_ff, default_est_in;
   logic [REQ_BITS-1:0]    op_kind_ff, op_kind_in;
   logic [ID_BITS-1:0]     op_id_ff, op_id_in;
   logic [EST_BITS-1:0]    op_est_ff, op_est_in;
   logic [SLOT_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [SLOT_BITS-1:0]   chk_idx_ff, chk_idx_in;
   logic                   match_ff, match_in;
   logic [SLOT_BITS-1:0]   match_idx_ff, match_idx_in;
   logic                   free_ff, free_in;
   logic [SLOT_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                   best_vld_ff, best_vld_in;
   logic [ID_BITS-1:0]     best_id_ff, best_id_in;
   logic [EST_BITS-1:0]    best_est_ff, best_est_in;
   logic [QUEUE_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pick_valid_ff, pick_valid_in;
   logic [ID_BITS-1:0]     pick_id_ff, pick_id_in;
   logic [EST_BITS-1:0]    pick_est_ff, pick_est_in;
   status_type             status_ff, status_in;

   logic [ENTRY_BITS-1:0]  ram_rdata;
   logic [ID_BITS-1:0]     entry_id;
   logic [EST_BITS-1:0]    entry_est;
   logic                   entry_v;
   logic                   entry_hit;
   logic                   entry_better;
   logic                   is_insert;
   logic                   is_remove;
   logic                   ins_ok;
   logic                   rem_ok;
   logic                   new_better;
   logic                   final_vld;
   logic [ID_BITS-1:0]     final_id;
   logic [EST_BITS-1:0]    final_est;
   status_type             final_status;

   sjfq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && ins_ok),
      .wr_addr (free_idx_ff),
      .wr_data ({op_id_ff, op_est_ff}),
      .rd_en   (cmd.step),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   assign entry_id  = ram_rdata[ENTRY_BITS-1:EST_BITS];
   assign entry_est = ram_rdata[EST_BITS-1:0];
   assign entry_v   = chk_vld_ff && slot_valid_ff[chk_idx_ff];
   assign entry_hit = entry_v && (entry_id == op_id_ff);
   assign entry_better = !best_vld_ff || (entry_est < best_est_ff) ||
                         ((entry_est == best_est_ff) && (entry_id < best_id_ff));

   assign is_insert = (op_kind_ff == REQ_INSERT);
   assign is_remove = (op_kind_ff == REQ_REMOVE);
   assign ins_ok    = is_insert && !match_ff && free_ff;
   assign rem_ok    = is_remove && match_ff;

   // the new task against the best of what was already held
   assign new_better = !best_vld_ff || (op_est_ff < best_est_ff) ||
                       ((op_est_ff == best_est_ff) && (op_id_ff < best_id_ff));
   assign final_vld  = best_vld_ff || ins_ok;
   assign final_id   = (ins_ok && new_better) ? op_id_ff : best_id_ff;
   assign final_est  = (ins_ok && new_better) ? op_est_ff : best_est_ff;

   always_comb begin
      priority if (is_insert && match_ff) begin
         final_status = ST_DUPLICATE;
      end else if (is_insert && !free_ff) begin
         final_status = ST_FULL;
      end else if (is_remove && !match_ff) begin
         final_status = ST_NOT_FOUND;
      end else begin
         final_status = ST_OK;
      end
   end

   always_comb begin
      default_est_in = csr_we ? csr_wdata : default_est_ff;
      op_kind_in     = op_kind_ff;
      op_id_in       = op_id_ff;
      op_est_in      = op_est_ff;
      rd_idx_in      = rd_idx_ff;
      chk_vld_in     = cmd.step;
      chk_idx_in     = rd_idx_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      best_vld_in    = best_vld_ff;
      best_id_in     = best_id_ff;
      best_est_in    = best_est_ff;
      slot_valid_in  = slot_valid_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      pick_valid_in  = pick_valid_ff;
      pick_id_in     = pick_id_ff;
      pick_est_in    = pick_est_ff;
      status_in      = status_ff;

      if (cmd.latch) begin
         op_kind_in  = req_type;
         op_id_in    = proc_id;
         op_est_in   = (est_time == '0) ? default_est_ff : est_time;
         rd_idx_in   = '0;
         match_in    = 1'b0;
         free_in     = 1'b0;
         best_vld_in = 1'b0;
      end

      if (cmd.step) begin
         rd_idx_in = rd_idx_ff + SLOT_BITS'(1);
      end

      // one slot per cycle through the accumulators
      if (entry_hit) begin
         match_in     = 1'b1;
         match_idx_in = chk_idx_ff;
      end
      if (chk_vld_ff && !slot_valid_ff[chk_idx_ff] && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = chk_idx_ff;
      end
      // a task about to be removed takes no part in the pick
      if (entry_v && !(is_remove && entry_hit) && entry_better) begin
         best_vld_in = 1'b1;
         best_id_in  = entry_id;
         best_est_in = entry_est;
      end

      if (cmd.commit) begin
         if (ins_ok) begin
            slot_valid_in[free_idx_ff] = 1'b1;
            count_in = count_ff + CNT_BITS'(1);
         end
         if (rem_ok) begin
            slot_valid_in[match_idx_ff] = 1'b0;
            count_in = count_ff - CNT_BITS'(1);
         end
         rsp_valid_in  = 1'b1;
         pick_valid_in = final_vld;
         pick_id_in    = final_vld ? final_id : '0;
         pick_est_in   = final_vld ? final_est : '0;
         status_in     = final_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_est_ff <= DEFAULT_EST_RESET;
         chk_vld_ff     <= 1'b0;
         match_ff       <= 1'b0;
         free_ff        <= 1'b0;
         best_vld_ff    <= 1'b0;
         slot_valid_ff  <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         default_est_ff <= default_est_in;
         chk_vld_ff     <= chk_vld_in;
         match_ff       <= match_in;
         free_ff        <= free_in;
         best_vld_ff    <= best_vld_in;
         slot_valid_ff  <= slot_valid_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_kind_ff    <= op_kind_in;
      op_id_ff      <= op_id_in;
      op_est_ff     <= op_est_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      best_id_ff    <= best_id_in;
      best_est_ff   <= best_est_in;
      pick_valid_ff <= pick_valid_in;
      pick_id_ff    <= pick_id_in;
      pick_est_ff   <= pick_est_in;
      status_ff     <= status_in;
   end

   assign sts.scan_last = (rd_idx_ff == SLOT_BITS'(QUEUE_DEPTH - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // the count only moves when a new response is loaded, so it can feed the port
   assign rsp_valid     = rsp_valid_ff;
   assign pick_valid    = pick_valid_ff;
   assign pick_id       = pick_id_ff;
   assign pick_estimate = pick_est_ff;
   assign queue_count   = QCNT_BITS'(count_ff);
   assign status        = status_ff;

endmodule

`default_nettype wire

// ===== rtl/shortest_job_first_queue.sv =====
// top level of the shortest job first run queue
// depends on sjfq_pkg, sjfq_req_if, sjfq_rsp_if, sjfq_ctrl, sjfq_dp
`timescale 1ns / 1ps
`default_nettype none

// Run queue holding up to QUEUE_DEPTH tasks, each an id and an estimated run
// time. A request inserts a task, removes a task by id or peeks; every request
// gives exactly one response with the best task (smallest estimate, ties to
// the smaller id), the task count after the request and a status (ok, full,
// id not found, id already present). An insert with zero estimate stores the
// csr default estimate (reset 100). The reserved request code behaves as a
// peek. Tasks live in a single ram that is swept one slot per cycle; a
// request is taken in the idle state and its response is loaded after the
// sweep through the ram read port, so no new request is taken before the
// response of the last one is loaded. The response sits in an output
// register, so the next request is taken while an earlier response still
// waits; a response is only held back when the one before it has not been
// taken.
module shortest_job_first_queue import sjfq_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   sjfq_req_if.sink                 req_port,
   sjfq_rsp_if.source               rsp_port,
   input  wire logic                csr_we,
   input  wire logic [EST_BITS-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;
   logic          req_ready;

   // sequencing: idle, slot sweep, read drain, commit
   sjfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot store, match / free / best search and response register
   sjfq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_type      (req_port.req_type),
      .proc_id       (req_port.proc_id),
      .est_time      (req_port.est_time),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_port.valid),
      .rsp_ready     (rsp_port.ready),
      .pick_valid    (rsp_port.pick_valid),
      .pick_id       (rsp_port.pick_id),
      .pick_estimate (rsp_port.pick_estimate),
      .queue_count   (rsp_port.queue_count),
      .status        (rsp_port.status)
   );

   // a transfer on the request side only happens in the idle state
   assign req_port.ready = req_ready;

endmodule

`default_nettype wire

// ===== rtl/sjfq_checker.sv =====
// port-level checks of the run queue, bound to the top level
// depends on sjfq_pkg and shortest_job_first_queue_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "shortest_job_first_queue_macros.svh"

module sjfq_checker import sjfq_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic                   pick_valid,
   input wire logic [ID_BITS-1:0]     pick_id,
   input wire logic [EST_BITS-1:0]    pick_estimate,
   input wire logic [QCNT_BITS-1:0]   queue_count,
   input wire logic [STATUS_BITS-1:0] status
);

   `SJFQ_ASSERT_NXT_ALL(a_no_rsp_after_reset, clock, reset, !rsp_valid)

   `SJFQ_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   `SJFQ_ASSERT_IMP(a_pick_matches_count, clock, reset, rsp_valid,
      (pick_valid == (queue_count != '0)) && (queue_count <= QCNT_BITS'(QUEUE_DEPTH)))

   `SJFQ_ASSERT_IMP(a_full_only_at_depth, clock, reset, rsp_valid && (status == ST_FULL),
      queue_count == QCNT_BITS'(QUEUE_DEPTH))

   `SJFQ_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(pick_id) && $stable(pick_estimate) && $stable(status))

endmodule

bind shortest_job_first_queue sjfq_checker u_sjfq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_port.valid),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .pick_valid    (rsp_port.pick_valid),
   .pick_id       (rsp_port.pick_id),
   .pick_estimate (rsp_port.pick_estimate),
   .queue_count   (rsp_port.queue_count),
   .status        (rsp_port.status)
);

`default_nettype wire

// ===== sim/tb_shortest_job_first_queue.sv =====
// self-checking testbench for the shortest job first run queue
// depends on sjfq_pkg, sjfq_req_if, sjfq_rsp_if and shortest_job_first_queue
`timescale 1ns / 1ps

module tb_shortest_job_first_queue;
   import sjfq_pkg::*;

   // the spare request code, taken by the block as a peek
   localparam logic [REQ_BITS-1:0] REQ_RESERVED = 2'd3;

   // cycles without any transfer before the run is declared hung; this leaves
   // a wide margin over the sweep of a request, the longest receiver stall
   // and the longest sender gap
   localparam int WATCHDOG_LIMIT = 2000;
   // settling time after the last response, from the sweep latency
   localparam int DRAIN_CYCLES   = 40;
   // how many of the latest inserted ids a remove usually aims at
   localparam int RECENT_IDS     = 48;

   // receiver behaviour, switched at each epoch boundary set by RX_EPOCH
   localparam int RX_EPOCH  = 600;
   localparam int RX_OPEN   = 0;
   localparam int RX_CHOPPY = 1;

   typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_kind_type;

   typedef struct packed {
      logic [REQ_BITS-1:0] kind;
      logic [ID_BITS-1:0]  proc_id;
      logic [EST_BITS-1:0] est_time;
   } sched_req_type;

   typedef struct packed {
      logic                 pick_valid;
      logic [ID_BITS-1:0]   pick_id;
      logic [EST_BITS-1:0]  pick_estimate;
      logic [QCNT_BITS-1:0] queue_count;
      status_type           status;
   } sched_rsp_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                csr_we    = 1'b0;
   logic [EST_BITS-1:0] csr_wdata = '0;

   sjfq_req_if req_bus ();
   sjfq_rsp_if rsp_bus ();

   shortest_job_first_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow run queue, updated at each accepted request
   logic                rq_used [QUEUE_DEPTH];
   logic [ID_BITS-1:0]  rq_id   [QUEUE_DEPTH];
   logic [EST_BITS-1:0] rq_est  [QUEUE_DEPTH];
   int                  rq_count   = 0;
   logic [EST_BITS-1:0] rq_default = DEFAULT_EST_RESET;

   sched_req_type       request_backlog [$];  // requests not yet on the bus
   sched_rsp_type       expected_picks  [$];  // responses still owed by the block
   logic [ID_BITS-1:0]  issued_ids      [$];  // every id ever sent in an insert
   logic [ID_BITS-1:0]  pool_base = '0;

   logic          req_taken   = 1'b0;
   int            mismatches  = 0;
   int            idle_cycles = 0;
   int            tx_burst    = 1;
   int            tx_gap      = 0;
   int            rx_stall    = 0;
   int            rx_cycles   = 0;
   sched_req_type next_req;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // apply one request to the shadow queue and work out the response it owes
   function automatic sched_rsp_type run_queue_step(input sched_req_type r);
      sched_rsp_type p;
      int            i;
      int            hit;
      int            free_slot;
      int            best;
      p         = '0;
      p.status  = ST_OK;
      hit       = -1;
      free_slot = -1;
      best      = -1;
      for (i = 0; i < QUEUE_DEPTH; i++) begin
         if (rq_used[i] && rq_id[i] == r.proc_id && hit < 0)
            hit = i;
         if (!rq_used[i] && free_slot < 0)
            free_slot = i;
      end
      case (r.kind)
         REQ_INSERT: begin
            // duplicate id wins over a full queue
            if (hit >= 0)
               p.status = ST_DUPLICATE;
            else if (free_slot < 0)
               p.status = ST_FULL;
            else begin
               rq_used[free_slot] = 1'b1;
               rq_id[free_slot]   = r.proc_id;
               rq_est[free_slot]  = (r.est_time == '0) ? rq_default : r.est_time;
               rq_count++;
            end
         end
         REQ_REMOVE: begin
            if (hit < 0)
               p.status = ST_NOT_FOUND;
            else begin
               rq_used[hit] = 1'b0;
               rq_count--;
            end
         end
         default: ;  // peek and the spare code change nothing
      endcase
      // smallest estimate first, ties to the smaller id
      for (i = 0; i < QUEUE_DEPTH; i++) begin
         if (rq_used[i] && (best < 0 || rq_est[i] < rq_est[best] ||
             (rq_est[i] == rq_est[best] && rq_id[i] < rq_id[best])))
            best = i;
      end
      if (best >= 0) begin
         p.pick_valid    = 1'b1;
         p.pick_id       = rq_id[best];
         p.pick_estimate = rq_est[best];
      end
      p.queue_count = QCNT_BITS'(rq_count);
      return p;
   endfunction

   task automatic check_field(input string field_name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field_name, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_request(input logic [REQ_BITS-1:0] kind,
                                input logic [ID_BITS-1:0] id,
                                input logic [EST_BITS-1:0] est);
      sched_req_type r;
      r.kind     = kind;
      r.proc_id  = id;
      r.est_time = est;
      request_backlog.push_back(r);
      if (kind == REQ_INSERT)
         issued_ids.push_back(id);
   endtask

   // zero, the top value and small values for ties are all favoured
   function automatic logic [EST_BITS-1:0] random_estimate();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15)
         return '0;
      if (roll < 25)
         return '1;
      if (roll < 50)
         return EST_BITS'($urandom_range(1, 4));
      return EST_BITS'($urandom);
   endfunction

   // one phase of random traffic; the mix decides how full the queue runs
   task automatic queue_phase(input mix_kind_type mix, input int n);
      int                 k;
      int                 roll;
      int                 lo;
      int                 insert_cut;
      int                 remove_cut;
      logic [ID_BITS-1:0] id;
      case (mix)
         MIX_FILL: begin
            insert_cut = 88;
            remove_cut = 95;
            pool_base  = ID_BITS'($urandom_range(0, (1 << ID_BITS) - 64));
         end
         MIX_CHURN: begin
            insert_cut = 40;
            remove_cut = 80;
         end
         default: begin
            insert_cut = 20;
            remove_cut = 90;
         end
      endcase
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < insert_cut) begin
            // ids from a narrow window so that duplicates turn up
            if ($urandom_range(0, 9) == 0)
               id = ID_BITS'($urandom);
            else
               id = pool_base + ID_BITS'($urandom_range(0, 63));
            queue_request(REQ_INSERT, id, random_estimate());
         end else if (roll < remove_cut) begin
            roll = $urandom_range(0, 99);
            if (issued_ids.size() == 0 || roll < 10)
               id = ID_BITS'($urandom);
            else if (roll < 30)
               id = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
            else begin
               lo = (issued_ids.size() > RECENT_IDS) ? issued_ids.size() - RECENT_IDS : 0;
               id = issued_ids[$urandom_range(lo, issued_ids.size() - 1)];
            end
            queue_request(REQ_REMOVE, id, EST_BITS'($urandom));
         end else
            queue_request($urandom_range(0, 1) ? REQ_PEEK : REQ_RESERVED,
                          ID_BITS'($urandom), EST_BITS'($urandom));
      end
   endtask

   // idle once nothing waits to be sent and every response is in
   task automatic wait_idle();
      do
         @(posedge clock);
      while (request_backlog.size() != 0 || req_bus.valid || expected_picks.size() != 0);
   endtask

   task automatic write_default(input logic [EST_BITS-1:0] value);
      @(negedge clock);
      csr_we     <= 1'b1;
      csr_wdata  <= value;
      rq_default = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver: holds each request until taken, then bursts and gaps
   always @(negedge clock) begin
      if (req_bus.valid && !req_taken) begin
         // still waiting for the block to take it
      end else if (tx_gap > 0) begin
         tx_gap = tx_gap - 1;
         req_bus.valid <= 1'b0;
      end else if (!reset && request_backlog.size() != 0) begin
         next_req = request_backlog.pop_front();
         req_bus.valid    <= 1'b1;
         req_bus.req_type <= next_req.kind;
         req_bus.proc_id  <= next_req.proc_id;
         req_bus.est_time <= next_req.est_time;
         if (tx_burst <= 1) begin
            tx_burst = $urandom_range(1, 8);
            tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else
            tx_burst = tx_burst - 1;
      end else
         req_bus.valid <= 1'b0;
   end

   // response receiver: open, choppy or slow, changing every epoch
   always @(negedge clock) begin
      rx_cycles = rx_cycles + 1;
      if (rx_stall > 0) begin
         rx_stall = rx_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         case ((rx_cycles / RX_EPOCH) % 3)
            RX_OPEN: ;
            RX_CHOPPY: begin
               if ($urandom_range(0, 99) < 35)
                  rx_stall = $urandom_range(1, 6);
            end
            default: begin
               if ($urandom_range(0, 99) < 6)
                  rx_stall = $urandom_range(10, 60);
            end
         endcase
      end
   end

   // request and response monitor, scoreboard and watchdog
   always @(posedge clock) begin
      sched_req_type seen;
      sched_rsp_type want;
      req_taken <= req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen.kind     = req_bus.req_type;
         seen.proc_id  = req_bus.proc_id;
         seen.est_time = req_bus.est_time;
         expected_picks.push_back(run_queue_step(seen));
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_picks.size() == 0) begin
            $error("response transfer with no request outstanding");
            mismatches++;
         end else begin
            want = expected_picks.pop_front();
            check_field("pick_valid", want.pick_valid, rsp_bus.pick_valid);
            check_field("pick_id", want.pick_id, rsp_bus.pick_id);
            check_field("pick_estimate", want.pick_estimate, rsp_bus.pick_estimate);
            check_field("queue_count", want.queue_count, rsp_bus.queue_count);
            check_field("status", want.status, rsp_bus.status);
         end
      end
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [EST_BITS-1:0] defaults [9];
      int                  p;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_PEEK;
      req_bus.proc_id  = '0;
      req_bus.est_time = '0;
      rsp_bus.ready    = 1'b0;
      for (p = 0; p < QUEUE_DEPTH; p++)
         rq_used[p] = 1'b0;
      defaults = '{16'hFFFF, 16'd1, 16'd0, EST_BITS'($urandom), DEFAULT_EST_RESET,
                   EST_BITS'($urandom), 16'd1, 16'hFFFF, 16'd0};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, default estimate still at its reset value
      queue_request(REQ_PEEK, 12'h000, 16'h0000);      // empty queue
      queue_request(REQ_REMOVE, 12'h005, 16'h0000);    // remove from empty
      queue_request(REQ_RESERVED, 12'hFFF, 16'hFFFF);  // spare code on empty
      queue_request(REQ_INSERT, 12'hFFF, 16'h0000);    // takes the default
      queue_request(REQ_INSERT, 12'h000, 16'hFFFF);    // lowest id, top estimate
      queue_request(REQ_INSERT, 12'hFFF, 16'h0007);    // duplicate id
      queue_request(REQ_INSERT, 12'h800, 16'd100);     // ties with the default, smaller id
      queue_request(REQ_INSERT, 12'h001, 16'h0001);    // new best
      queue_request(REQ_PEEK, 12'hABC, 16'hFFFF);      // peek fields ignored
      queue_request(REQ_RESERVED, 12'h001, 16'h0000);
      queue_request(REQ_REMOVE, 12'h001, 16'h0000);    // best removed
      queue_request(REQ_REMOVE, 12'h001, 16'h0000);    // now absent
      queue_request(REQ_INSERT, 12'h555, 16'hAAAA);
      queue_request(REQ_INSERT, 12'hAAA, 16'h5555);
      queue_request(REQ_INSERT, 12'h7FF, 16'h5555);    // tie on estimate
      queue_request(REQ_REMOVE, 12'h800, 16'hFFFF);
      queue_request(REQ_REMOVE, 12'hFFF, 16'h0000);
      queue_request(REQ_REMOVE, 12'h000, 16'h0000);
      queue_request(REQ_REMOVE, 12'h555, 16'h0000);
      queue_request(REQ_REMOVE, 12'hAAA, 16'h0000);
      queue_request(REQ_REMOVE, 12'h7FF, 16'h0000);    // back to empty
      queue_request(REQ_PEEK, 12'h000, 16'h0000);

      // random phases, each under its own default estimate
      for (p = 0; p < 9; p++) begin
         wait_idle();
         write_default(defaults[p]);
         case (p % 3)
            0: queue_phase(MIX_FILL, 76);
            1: queue_phase(MIX_CHURN, 76);
            default: queue_phase(MIX_DRAIN, 76);
         endcase
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_picks.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
